// ===== rtl/core/fbsro_pkg.sv =====
// Shared types and constants for the framebuffer span raster-op engine.
// Holds the sequencer state type, command, raster-op and register codes.
// No dependencies.
package fbsro_pkg;

  // Widths fixed by the command fields.
  localparam int COORD_W  = 8;
  localparam int PITCH_W  = 9;
  localparam int PIXEL_W  = 32;
  localparam int ROP_W    = 5;
  localparam int MODE_W   = 2;
  // Largest row * pitch + column is 255 * 511 + 255, which fits in 17 bits.
  localparam int AGU_W    = 17;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 9'd256;

  // Command kinds.
  localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HSPAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VSPAN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Register indexes.
  localparam logic CFG_ROW_PITCH  = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  // Raster operations.
  localparam logic [ROP_W-1:0] ROP_COPY     = 5'd0;
  localparam logic [ROP_W-1:0] ROP_XOR_BG   = 5'd1;
  localparam logic [ROP_W-1:0] ROP_TRANS    = 5'd2;
  localparam logic [ROP_W-1:0] ROP_XOR      = 5'd3;
  localparam logic [ROP_W-1:0] ROP_AND      = 5'd4;
  localparam logic [ROP_W-1:0] ROP_OR       = 5'd5;
  localparam logic [ROP_W-1:0] ROP_CLEAR    = 5'd6;
  localparam logic [ROP_W-1:0] ROP_SET      = 5'd7;
  localparam logic [ROP_W-1:0] ROP_EQUIV    = 5'd8;
  localparam logic [ROP_W-1:0] ROP_NOR      = 5'd9;
  localparam logic [ROP_W-1:0] ROP_NAND     = 5'd10;
  localparam logic [ROP_W-1:0] ROP_INVERT   = 5'd11;
  localparam logic [ROP_W-1:0] ROP_COPYINV  = 5'd12;
  localparam logic [ROP_W-1:0] ROP_ORINV    = 5'd13;
  localparam logic [ROP_W-1:0] ROP_ANDINV   = 5'd14;
  localparam logic [ROP_W-1:0] ROP_ORREV    = 5'd15;
  localparam logic [ROP_W-1:0] ROP_ANDREV   = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_LAST,
    ST_CHECK,
    ST_READ,
    ST_MODIFY,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/fbsro_rop.sv =====
// Raster-operation combiner: merges a stored pixel with the source color.
// Depends on fbsro_pkg for the operation codes.
module fbsro_rop import fbsro_pkg::*; (
  input  logic [ROP_W-1:0]   op,
  input  logic [PIXEL_W-1:0] dst,
  input  logic [PIXEL_W-1:0] src,
  input  logic [PIXEL_W-1:0] bg,
  output logic [PIXEL_W-1:0] result
);

  always_comb begin
    case (op)
      ROP_COPY:    result = src;
      ROP_XOR_BG:  result = dst ^ src ^ bg;
      ROP_TRANS:   result = (dst != '0) ? dst : src;
      ROP_XOR:     result = dst ^ src;
      ROP_AND:     result = dst & src;
      ROP_OR:      result = dst | src;
      ROP_CLEAR:   result = '0;
      ROP_SET:     result = '1;
      ROP_EQUIV:   result = ~(dst ^ src);
      ROP_NOR:     result = ~(dst | src);
      ROP_NAND:    result = ~(dst & src);
      ROP_INVERT:  result = ~dst;
      ROP_COPYINV: result = ~src;
      ROP_ORINV:   result = dst | ~src;
      ROP_ANDINV:  result = dst & ~src;
      ROP_ORREV:   result = ~dst | src;
      ROP_ANDREV:  result = ~dst & src;
      // No-op and the unused codes leave the pixel as it is.
      default:     result = dst;
    endcase
  end

endmodule

// ===== rtl/core/fbsro_agu.sv =====
// Address unit: one registered multiply-add, row * pitch + column.
// Shared by the start and end address of every command. Depends on fbsro_pkg.
module fbsro_agu import fbsro_pkg::*; (
  input  logic                clk,
  input  logic [COORD_W-1:0]  row,
  input  logic [COORD_W-1:0]  col,
  input  logic [PITCH_W-1:0]  pitch,
  output logic [AGU_W-1:0]    addr
);

  logic [AGU_W-1:0] prod;

  always_comb begin
    prod = AGU_W'(row) * AGU_W'(pitch) + AGU_W'(col);
  end

  always_ff @(posedge clk) begin
    addr <= prod;
  end

endmodule

// ===== rtl/core/framebuffer_span_raster_op.sv =====
// Top level of the framebuffer span raster-op engine: sequencer, pixel store
// and output register. Depends on fbsro_pkg, fbsro_agu and fbsro_rop.
//
// Commands arrive on the s_ channel, one request each, with the command kind in
// s_tuser; each returns exactly one result request on the m_ channel. Row pitch
// and background color are set through the cfg_ port; the user must write them
// only while nothing is in flight, as the block itself does not enforce it.
//
// After a request is taken, a command steps through its start and end addresses
// (one shared multiply-add), the range check, a read and a write per pixel (on
// the single store port) and a finish step that loads the output register. A
// read or a single pixel has one such pixel pass (a read writes nothing), a span
// of n pixels n, and an empty span or an out-of-range command none. s_tready is
// high only in the idle step that follows, so commands do not overlap.
//
// rst is synchronous. After it the store is cleared one pixel per cycle, all
// FB_WIDTH * FB_HEIGHT pixels (65536 at the defaults); configuration writes are
// taken during that pass, commands are not. If the receiver holds m_tready low,
// a finished command waits in its last step until the output register frees.
module framebuffer_span_raster_op import fbsro_pkg::*; #(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // Command channel.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // tdata from bit 0: x_coord[7:0], y_coord[15:8], end_coord[23:16],
  // color[55:24], rop[60:56], zero padding[63:61]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // tuser: mode[1:0]
  input  logic [MODE_W-1:0]    s_tuser,
  // Result channel.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // tdata from bit 0: pixel_value[31:0], status[32], zero padding[39:33]
  output logic [M_TDATA_W-1:0] m_tdata,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [PIXEL_W-1:0]   cfg_data
);

  localparam int STORE_SIZE = FB_WIDTH * FB_HEIGHT;
  localparam int AW = $clog2(STORE_SIZE);
  // Address width that holds both a store index and any computed address.
  localparam int CW = ((AW > AGU_W) ? AW : AGU_W) + 1;
  localparam logic [CW-1:0] SIZE_C = CW'(STORE_SIZE);
  localparam logic [AW-1:0] LAST_INDEX = AW'(STORE_SIZE - 1);

  // Configuration registers.
  logic [PITCH_W-1:0] row_pitch;
  logic [PIXEL_W-1:0] background_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch        <= PITCH_RESET;
      background_color <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_PITCH:  row_pitch <= cfg_data[PITCH_W-1:0];
        CFG_BACKGROUND: background_color <= cfg_data;
        default:        row_pitch <= row_pitch;
      endcase
    end
  end

  // Command fields, latched when the request is taken.
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COORD_W-1:0] end_coord;
  logic [PIXEL_W-1:0] color;
  logic [ROP_W-1:0]   rop;

  state_t state;
  state_t state_next;

  logic               take;
  logic [COORD_W-1:0] agu_row;
  logic [COORD_W-1:0] agu_col;
  logic [AGU_W-1:0]   agu_addr;
  logic               mem_re;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;
  logic [PIXEL_W-1:0] rd_data;
  logic [PIXEL_W-1:0] rop_result;
  logic               out_load;

  // Sequencer working registers.
  logic [CW-1:0]      addr;
  logic [CW-1:0]      step;
  logic [COORD_W-1:0] cnt;
  logic [AW-1:0]      clr;
  logic [PIXEL_W-1:0] res_pixel;
  logic               res_status;

  // Range check, valid in the check step: agu_addr then holds the last address.
  logic empty_span;
  logic out_of_range;
  logic read_out_of_range;

  always_comb begin
    empty_span = ((mode == MODE_HSPAN) && (end_coord < x_coord)) ||
                 ((mode == MODE_VSPAN) && (end_coord < y_coord));
    out_of_range      = CW'(agu_addr) >= SIZE_C;
    read_out_of_range = addr >= SIZE_C;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr == LAST_INDEX) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_START;
      ST_START:  state_next = ST_LAST;
      ST_LAST:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (mode == MODE_READ) begin
          state_next = read_out_of_range ? ST_FINISH : ST_READ;
        end else if (empty_span || out_of_range) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: begin
        if (mode == MODE_READ || cnt == '0) state_next = ST_FINISH;
        else state_next = ST_READ;
      end
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs of each step.
  always_comb begin
    s_tready  = 1'b0;
    agu_row   = y_coord;
    agu_col   = x_coord;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr[AW-1:0];
    mem_wdata = rop_result;
    out_load  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = '0;
      end
      ST_IDLE:  s_tready = 1'b1;
      ST_LAST: begin
        // End address: a horizontal span ends on its own row, a vertical
        // span in its own column, a single pixel or a read at its start.
        if (mode == MODE_HSPAN) begin
          agu_col = end_coord;
        end else if (mode == MODE_VSPAN) begin
          agu_row = end_coord;
        end
      end
      ST_READ:   mem_re = 1'b1;
      ST_MODIFY: mem_we = (mode != MODE_READ);
      ST_FINISH: out_load = !m_tvalid || m_tready;
      default:   s_tready = 1'b0;
    endcase
  end

  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_coord   <= s_tdata[7:0];
      y_coord   <= s_tdata[15:8];
      end_coord <= s_tdata[23:16];
      color     <= s_tdata[55:24];
      rop       <= s_tdata[60:56];
      mode      <= s_tuser;
    end
  end

  // Address walk and per-command result.
  always_ff @(posedge clk) begin
    case (state)
      ST_LAST: begin
        addr <= CW'(agu_addr);
        case (mode)
          MODE_HSPAN: step <= CW'(1);
          MODE_VSPAN: step <= CW'(row_pitch);
          default:    step <= '0;
        endcase
      end
      ST_CHECK: begin
        res_pixel <= '0;
        case (mode)
          MODE_HSPAN: cnt <= end_coord - x_coord;
          MODE_VSPAN: cnt <= end_coord - y_coord;
          default:    cnt <= '0;
        endcase
        if (mode == MODE_READ) res_status <= read_out_of_range;
        else res_status <= !empty_span && out_of_range;
      end
      ST_MODIFY: begin
        if (mode == MODE_READ) res_pixel <= rd_data;
        addr <= addr + step;
        cnt  <= cnt - 1'b1;
      end
      default: addr <= addr;
    endcase
  end

  fbsro_agu u_agu (
    .clk   (clk),
    .row   (agu_row),
    .col   (agu_col),
    .pitch (row_pitch),
    .addr  (agu_addr)
  );

  fbsro_rop u_rop (
    .op     (rop),
    .dst    (rd_data),
    .src    (color),
    .bg     (background_color),
    .result (rop_result)
  );

  // Pixel store: one write port, one registered read port.
  logic [PIXEL_W-1:0] pixel_store [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (mem_we) pixel_store[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= pixel_store[addr[AW-1:0]];
  end

  // Output register.
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel  <= res_pixel;
      out_status <= res_status;
    end
  end

  assign m_tdata = {(M_TDATA_W - PIXEL_W - 1)'(0), out_status, out_pixel};

endmodule

// ===== dv/framebuffer_span_raster_op_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for framebuffer_span_raster_op: a directed table, then random phases.
// Depends on fbsro_pkg and the framebuffer_span_raster_op RTL only.
module framebuffer_span_raster_op_tb;
  import fbsro_pkg::*;

  // The package names raster operations 0 to 16. Operation 17 is the no-op, and every code
  // above it behaves the same way.
  localparam logic [ROP_W-1:0] ROP_NOOP       = 5'd17;
  localparam logic [ROP_W-1:0] ROP_UNUSED_TOP = 5'd31;

  localparam int FB_PIXELS       = 256 * 256;
  localparam int NUM_DIRECTED    = 28;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 68;
  // Receiver hold-off, long enough to fill the output register and stall the command side.
  localparam int LONG_HOLD       = 3000;
  // The clearing pass after reset moves no request while it clears all 65536 pixels. No other
  // correct stretch comes near this limit, neither the longest span nor the LONG_HOLD hold-off.
  localparam int WATCHDOG_LIMIT  = 200000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [7:0]         x;
    logic [7:0]         y;
    logic [7:0]         e;
    logic [PIXEL_W-1:0] color;
    logic [ROP_W-1:0]   rop;
  } raster_cmd_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               status;
  } raster_result_t;

  // A row of the directed table. When 'typed' is set, the result is written in the row
  // itself. Otherwise the mirror below computes it.
  typedef struct {
    int unsigned        pitch;
    logic [MODE_W-1:0]  mode;
    logic [7:0]         x;
    logic [7:0]         y;
    logic [7:0]         e;
    logic [PIXEL_W-1:0] color;
    logic [ROP_W-1:0]   rop;
    bit                 typed;
    logic [PIXEL_W-1:0] pix;
    logic               st;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [PIXEL_W-1:0]   cfg_data = '0;

  framebuffer_span_raster_op u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the block. Its pixel store starts at zero, the same as the store that the RTL
  // clears after reset. The registers start at their reset values.
  bit   [PIXEL_W-1:0] fb_mirror [FB_PIXELS];
  logic [PITCH_W-1:0] mirror_pitch = PITCH_RESET;
  logic [PIXEL_W-1:0] mirror_bg = '0;

  // Results predicted for accepted commands and still owed by the block, oldest first.
  raster_result_t pending_pixels [$];

  int unsigned mismatches = 0;
  int unsigned n_reads = 0;
  int unsigned n_draws = 0;
  int unsigned n_outside = 0;
  int unsigned settings_written = 0;

  // These steer the random part. The hot window keeps most commands on a few dozen pixels, so
  // that reads find pixels that earlier draws have already written.
  bit          no_gaps = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hot_x = 1;
  int unsigned hot_y = 1;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // After reset the store is cleared and the pitch is 256.
    '{256, MODE_READ,  8'd0,   8'd0,   8'd0,   32'h0000_0000, ROP_COPY,       1, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd0,   8'd0,   8'd255, 32'hFFFF_FFFF, ROP_COPY,       1, 32'h0, 1'b0},
    '{256, MODE_READ,  8'd0,   8'd0,   8'd255, 32'h0000_0000, ROP_UNUSED_TOP,
      1, 32'hFFFF_FFFF, 1'b0},
    // Full last row, then the full last column. Both end exactly on the last pixel.
    '{256, MODE_HSPAN, 8'd0,   8'd255, 8'd255, 32'h0000_0000, ROP_SET,        1, 32'h0, 1'b0},
    '{256, MODE_VSPAN, 8'd255, 8'd0,   8'd255, 32'h5A5A_5A5A, ROP_XOR,        1, 32'h0, 1'b0},
    '{256, MODE_READ,  8'd255, 8'd255, 8'd0,   32'h0000_0000, ROP_COPY,
      1, 32'hA5A5_A5A5, 1'b0},
    // Spans whose end lies before their start. They draw nothing and still report done.
    '{256, MODE_HSPAN, 8'd9,   8'd2,   8'd8,   32'h1234_5678, ROP_UNUSED_TOP, 1, 32'h0, 1'b0},
    '{256, MODE_VSPAN, 8'd3,   8'd9,   8'd8,   32'h1234_5678, ROP_NOOP,       1, 32'h0, 1'b0},
    // A chain of raster operations on pixel (7,7). The first span gives transparent copy an
    // empty destination. The next command gives it a filled one.
    '{256, MODE_HSPAN, 8'd4,   8'd7,   8'd9,   32'h1111_1111, ROP_TRANS,      0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h2222_2222, ROP_TRANS,      0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h0F0F_0F0F, ROP_XOR_BG,     0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'hF0F0_FFFF, ROP_AND,        0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h00FF_0000, ROP_OR,         0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h3C3C_3C3C, ROP_EQUIV,      0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h0000_0001, ROP_NOR,        0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h0101_0101, ROP_NAND,       0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h8080_8080, ROP_ORINV,      0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h7E7E_7E7E, ROP_ANDINV,     0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h0000_FFFF, ROP_ORREV,      0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h1357_9BDF, ROP_ANDREV,     0, 32'h0, 1'b0},
    '{256, MODE_PIXEL, 8'd7,   8'd7,   8'd0,   32'h0000_0000, ROP_INVERT,     0, 32'h0, 1'b0},
    '{256, MODE_READ,  8'd7,   8'd7,   8'd0,   32'h0000_0000, ROP_COPY,       0, 32'h0, 1'b0},
    // With a pitch of 511, row 128 starts at 65408. A two-row span and a read at column 255
    // both leave the store. A span over columns 0 to 127 ends exactly on its last pixel.
    '{511, MODE_VSPAN, 8'd0,   8'd128, 8'd129, 32'hFFFF_FFFF, ROP_CLEAR,      1, 32'h0, 1'b1},
    '{511, MODE_READ,  8'd255, 8'd128, 8'd0,   32'h0000_0000, ROP_COPY,       1, 32'h0, 1'b1},
    '{511, MODE_HSPAN, 8'd0,   8'd128, 8'd127, 32'hF452_0FF2, ROP_COPYINV,    1, 32'h0, 1'b0},
    '{511, MODE_READ,  8'd127, 8'd128, 8'd0,   32'h0000_0000, ROP_COPY,
      1, 32'h0BAD_F00D, 1'b0},
    // With a pitch of zero, every row maps onto row 0, so the span hits one pixel three times.
    '{0,   MODE_VSPAN, 8'd5,   8'd0,   8'd2,   32'h0000_0003, ROP_XOR,        0, 32'h0, 1'b0},
    '{0,   MODE_READ,  8'd5,   8'd200, 8'd0,   32'h0000_0000, ROP_COPY,       0, 32'h0, 1'b0}
  };

  function automatic logic [PIXEL_W-1:0] rop_apply(logic [ROP_W-1:0] op,
                                                   logic [PIXEL_W-1:0] d,
                                                   logic [PIXEL_W-1:0] s);
    case (op)
      ROP_COPY:    return s;
      ROP_XOR_BG:  return d ^ s ^ mirror_bg;
      ROP_TRANS:   return (d != '0) ? d : s;
      ROP_XOR:     return d ^ s;
      ROP_AND:     return d & s;
      ROP_OR:      return d | s;
      ROP_CLEAR:   return '0;
      ROP_SET:     return '1;
      ROP_EQUIV:   return ~(d ^ s);
      ROP_NOR:     return ~(d | s);
      ROP_NAND:    return ~(d & s);
      ROP_INVERT:  return ~d;
      ROP_COPYINV: return ~s;
      ROP_ORINV:   return d | ~s;
      ROP_ANDINV:  return d & ~s;
      ROP_ORREV:   return ~d | s;
      ROP_ANDREV:  return ~d & s;
      default:     return d;
    endcase
  endfunction

  // Applies one command to the mirror and returns the result that the block owes for it. The
  // whole span is checked against the store before any pixel is touched.
  function automatic raster_result_t predict_raster_cmd(raster_cmd_t c);
    raster_result_t r;
    int unsigned    start;
    int unsigned    count;
    int unsigned    stride;
    int unsigned    addr;
    r.pixel  = '0;
    r.status = 1'b0;
    count    = 0;
    stride   = 0;
    start    = 32'(c.y) * 32'(mirror_pitch) + 32'(c.x);
    case (c.mode)
      MODE_READ: begin
        if (start < FB_PIXELS) r.pixel = fb_mirror[start];
        else r.status = 1'b1;
      end
      MODE_PIXEL: begin
        count = 1;
      end
      MODE_HSPAN: begin
        if (c.e >= c.x) count = 32'(c.e) - 32'(c.x) + 1;
        stride = 1;
      end
      default: begin
        if (c.e >= c.y) count = 32'(c.e) - 32'(c.y) + 1;
        stride = 32'(mirror_pitch);
      end
    endcase
    if (count != 0) begin
      if (start + (count - 1) * stride >= FB_PIXELS) begin
        r.status = 1'b1;
      end else begin
        for (int unsigned i = 0; i < count; i++) begin
          addr = start + i * stride;
          fb_mirror[addr] = rop_apply(c.rop, fb_mirror[addr], c.color);
        end
      end
    end
    return r;
  endfunction

  // Gap lengths for both sides: most are zero or short, and a few run far longer.
  function automatic int unsigned next_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Three random commands in four stay inside the hot window, with short spans and now and
  // then an empty one. The rest draw every field from its full range.
  function automatic raster_cmd_t random_cmd();
    raster_cmd_t c;
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(0, 9);
    c.mode = (pick < 3) ? MODE_READ : (pick < 6) ? MODE_PIXEL :
             (pick < 8) ? MODE_HSPAN : MODE_VSPAN;
    if ($urandom_range(0, 99) < 75) begin
      c.x     = 8'(hot_x + $urandom_range(0, 7));
      c.y     = 8'(hot_y + $urandom_range(0, 7));
      base    = (c.mode == MODE_VSPAN) ? 32'(c.y) : 32'(c.x);
      c.e     = 8'(base + $urandom_range(0, 7) - 1);
      c.color = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom);
      c.rop   = 5'($urandom_range(0, 19));
      if (c.rop > ROP_NOOP) c.rop = 5'($urandom_range(18, 31));
    end else begin
      c.x     = 8'($urandom);
      c.y     = 8'($urandom);
      c.e     = 8'($urandom);
      c.color = 32'($urandom);
      c.rop   = 5'($urandom);
    end
    return c;
  endfunction

  // All driving tasks start and end just after a falling edge. s_tvalid stays high after an
  // accepted request. The next send keeps it high or lowers it, and a drain always lowers it.
  task automatic send_cmd(raster_cmd_t c, bit typed, raster_result_t typed_res);
    raster_result_t r;
    int unsigned    gap;
    gap = next_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, c.rop, c.color, c.e, c.y, c.x};
    s_tuser  <= c.mode;
    do @(posedge clk); while (!s_tready);
    r = predict_raster_cmd(c);
    pending_pixels.push_back(typed ? typed_res : r);
    if (c.mode == MODE_READ) n_reads++;
    else n_draws++;
    if (r.status) n_outside++;
    @(negedge clk);
  endtask

  // Stops offering requests and waits until the block has returned every result it owes.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic cfg_write(logic idx, logic [PIXEL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_ROW_PITCH) mirror_pitch = val[PITCH_W-1:0];
    else mirror_bg = val;
    settings_written++;
  endtask

  // Result side. The receiver normally stalls for random gaps. When the stimulus asks for it,
  // the receiver refuses results for a LONG_HOLD hold-off while commands are still offered.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready   <= 1'b1;
        stall_left = next_gap();
      end
    end
  end

  // Every accepted result is compared field by field with the oldest owed result.
  always @(posedge clk) begin
    raster_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: result %h arrived with no request outstanding", $time, m_tdata);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[PIXEL_W-1:0] !== want.pixel) begin
          mismatches++;
          $display("%0t: pixel_value expected %h, got %h", $time, want.pixel,
                   m_tdata[PIXEL_W-1:0]);
        end
        if (m_tdata[PIXEL_W] !== want.status) begin
          mismatches++;
          $display("%0t: status expected %b, got %b", $time, want.status, m_tdata[PIXEL_W]);
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a request for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("framebuffer_span_raster_op: mismatch");
    $finish;
  end

  initial begin
    int unsigned    phase_pitch [NUM_PHASES];
    logic [31:0]    phase_bg [NUM_PHASES];
    raster_cmd_t    c;
    raster_result_t typed_res;
    raster_result_t no_typed;

    no_typed = '0;
    // The pitch settings include the extremes (zero, one and 511) and the reset value. The
    // background settings include all zeros and all ones.
    phase_pitch = '{1, 511, 0, 256, $urandom_range(1, 256), $urandom_range(257, 511),
                    $urandom_range(2, 255)};
    phase_bg    = '{32'hFFFF_FFFF, $urandom, 32'h0, $urandom, $urandom, $urandom, $urandom};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Configuration writes are taken during the clearing pass, so the background is set now.
    // The pitch stays at its reset value for the first rows of the table.
    cfg_write(CFG_BACKGROUND, 32'hC3A5_5A3C);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].pitch != 32'(mirror_pitch)) begin
        drain_results();
        cfg_write(CFG_ROW_PITCH, directed_rows[i].pitch);
      end
      c.mode          = directed_rows[i].mode;
      c.x             = directed_rows[i].x;
      c.y             = directed_rows[i].y;
      c.e             = directed_rows[i].e;
      c.color         = directed_rows[i].color;
      c.rop           = directed_rows[i].rop;
      typed_res.pixel  = directed_rows[i].pix;
      typed_res.status = directed_rows[i].st;
      send_cmd(c, directed_rows[i].typed, typed_res);
    end

    // The random phases. Each phase waits for the block to go idle and then writes both
    // registers. The phase with the reset pitch runs with no gaps on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      cfg_write(CFG_ROW_PITCH, phase_pitch[p]);
      cfg_write(CFG_BACKGROUND, phase_bg[p]);
      hot_x   = $urandom_range(1, 240);
      hot_y   = $urandom_range(1, 240);
      no_gaps = (p == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 1 && i == 5) hold_request = 1'b1;
        send_cmd(random_cmd(), 1'b0, no_typed);
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    $display("Ran %0d draw and %0d read requests over %0d register writes;", n_draws, n_reads,
             settings_written);
    $display("%0d of them fell outside the store.", n_outside);
    if (mismatches == 0) begin
      $display("framebuffer_span_raster_op: match");
    end else begin
      $display("framebuffer_span_raster_op: mismatch");
    end
    $finish;
  end

endmodule
